// ----- sv/adsr_square_voice_core_assert.svh -----
// assertion macros for the adsr square voice core
// expects clk_i and rst_ni in the scope of each use
`ifndef ADSR_SQUARE_VOICE_CORE_ASSERT_SVH
`define ADSR_SQUARE_VOICE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ASV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adsr voice check failed");

// next-cycle implication, disabled in reset
`define ASV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adsr voice check failed");

`endif

// ----- sv/asv_pkg.sv -----
// shared types, constants and tables for the adsr square voice core
// no dependencies
`default_nettype none

package asv_pkg;

  // sample clock and time width
  localparam int unsigned SAMPLE_RATE_HZ = 48000;
  localparam int unsigned TIME_BITS      = 32;
  localparam int unsigned NUM_TONES      = 96;
  localparam int unsigned TONE_W         = 7;
  localparam int unsigned TICK_W         = 24;
  localparam int unsigned Q15_W          = 15;

  // divider sizing: numerator = x * y with x < den, y < 2^15
  localparam int unsigned NUM_W     = TICK_W + Q15_W;
  localparam int unsigned DIV_STEPS = Q15_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [2:0] REG_START_TIME    = 3'd0;
  localparam logic [2:0] REG_RELEASE_TIME  = 3'd1;
  localparam logic [2:0] REG_TONE          = 3'd2;
  localparam logic [2:0] REG_ATTACK_TICKS  = 3'd3;
  localparam logic [2:0] REG_DECAY_TICKS   = 3'd4;
  localparam logic [2:0] REG_RELEASE_TICKS = 3'd5;
  localparam logic [2:0] REG_LEVELS        = 3'd6;
  localparam logic [2:0] REG_STEREO_GAINS  = 3'd7;

  // register reset values
  localparam logic [TIME_BITS-1:0] RST_START_TIME    = '0;
  localparam logic [TIME_BITS-1:0] RST_RELEASE_TIME  = '1;
  localparam logic [TONE_W-1:0]    RST_TONE          = 7'd49;
  localparam logic [TICK_W-1:0]    RST_ATTACK_TICKS  = 24'd480;
  localparam logic [TICK_W-1:0]    RST_DECAY_TICKS   = 24'd4800;
  localparam logic [TICK_W-1:0]    RST_RELEASE_TICKS = 24'd4800;
  localparam logic [31:0]          RST_LEVELS        = 32'h7FFF_8000;
  localparam logic [31:0]          RST_STEREO_GAINS  = 32'h7FFF_7FFF;

  // beat payloads
  typedef struct packed {
    logic [TIME_BITS-1:0] sample_time;
    logic                 channel;
  } asv_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               still_active;
  } asv_out_t;

  // divider handshake with the sequencer
  typedef struct packed {
    logic done;
    logic busy;
  } asv_div_stat_t;

  // 27.5 * 2^(k/12) Hz in Q16.16
  localparam logic [11:0][31:0] OCTAVE_Q16 = {
    32'd3402176, 32'd3211227, 32'd3030994, 32'd2860878,
    32'd2700309, 32'd2548752, 32'd2405702, 32'd2270680,
    32'd2143237, 32'd2022946, 32'd1909407, 32'd1802240
  };

  typedef logic [NUM_TONES-1:0][31:0] inc_lut_t;

  // phase increment per tone, rounded, worked out at elaboration
  function automatic inc_lut_t build_inc_lut();
    inc_lut_t    lut;
    logic [63:0] f;
    logic [63:0] inc;
    lut = '0;
    for (int oct = 0; oct < 8; oct++) begin
      for (int k = 0; k < 12; k++) begin
        f   = 64'(OCTAVE_Q16[k]) << oct;
        inc = ((f << 16) + 64'(SAMPLE_RATE_HZ / 2)) / SAMPLE_RATE_HZ;
        lut[oct * 12 + k] = inc[31:0];
      end
    end
    return lut;
  endfunction

  localparam inc_lut_t INC_LUT = build_inc_lut();

  // clamp a 16-bit field to q0.15
  function automatic logic [Q15_W-1:0] sat15(input logic [15:0] v);
    return v[15] ? {Q15_W{1'b1}} : v[Q15_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/asv_divider.sv -----
// restoring divider, one quotient bit per cycle, quotient below 2^15
// depends on asv_pkg
`default_nettype none

module asv_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [asv_pkg::NUM_W-1:0]   num_i,
  input  wire logic [asv_pkg::TICK_W-1:0]  den_i,
  output asv_pkg::asv_div_stat_t           stat_o,
  output logic [asv_pkg::Q15_W-1:0]        quot_o
);
  import asv_pkg::*;

  localparam int unsigned DSH_W = TICK_W + DIV_STEPS - 1;
  localparam logic [DCNT_W-1:0] LAST_CNT = DCNT_W'(DIV_STEPS - 1);

  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [DSH_W-1:0]  dsh_q, dsh_d;
  logic [Q15_W-1:0]  quot_q, quot_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              fits;
  logic [NUM_W-1:0]  dsh_ext;

  // trial subtract of the shifted divisor
  assign dsh_ext = NUM_W'(dsh_q);
  assign fits    = rem_q >= dsh_ext;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = {den_i, {(DIV_STEPS - 1){1'b0}}};
      quot_d = '0;
      cnt_d  = LAST_CNT;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_ext;
      end
      quot_d = {quot_q[Q15_W-2:0], fits};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.busy = busy_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

// ----- sv/adsr_square_voice_core.sv -----
// Attack, decay and release ramps pass through the bit-serial divider; the level
// needs no division before start, in sustain and after the end of release.
// A new input beat is taken only once the previous one is done; a finished
// result waits in the output register while the next beat is taken.
// Reset: configuration registers take their defaults, note active is set.
`default_nettype none

`include "adsr_square_voice_core_assert.svh"

module adsr_square_voice_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration writes
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_wdata_i,
  // input beats
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire asv_pkg::asv_in_t  in_data_i,
  // result beats
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output asv_pkg::asv_out_t      out_data_o
);
  import asv_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MULA  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_LEVEL = 3'd4;
  localparam logic [2:0] S_MULP  = 3'd5;
  localparam logic [2:0] S_MULG  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [1:0] LVL_DIRECT = 2'd0;
  localparam logic [1:0] LVL_ADD    = 2'd1;
  localparam logic [1:0] LVL_SUB    = 2'd2;

  localparam logic [TONE_W-1:0] TONE_MIN = 7'd1;
  localparam logic [TONE_W-1:0] TONE_MAX = TONE_W'(NUM_TONES);
  localparam logic [30:0]       ROUND_HALF = 31'd16384;

  // configuration registers
  logic [TIME_BITS-1:0] start_time_q, release_time_q;
  logic [TONE_W-1:0]    tone_q;
  logic [TICK_W-1:0]    attack_ticks_q, decay_ticks_q, release_ticks_q;
  logic [31:0]          levels_q, stereo_gains_q;

  // sequencer and item state
  logic [2:0]           state_q, state_d;
  logic                 note_active_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 chan_q;
  logic [TICK_W-1:0]    x_q, den_q;
  logic [Q15_W-1:0]     y_q, base_q, level_q, gain_q;
  logic [1:0]           lvl_mode_q;
  logic                 is_attack_q, started_q;
  logic [31:0]          inc_q;
  logic                 phase_pos_q;
  logic [29:0]          prod_q;
  logic                 out_valid_q;
  asv_out_t             out_q;

  // shared multiplier
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          mul_res;

  // divider
  asv_div_stat_t        div_stat;
  logic [Q15_W-1:0]     quot;
  logic                 div_start;

  // setup decode
  logic [Q15_W-1:0]     peak, sus;
  logic                 started, in_attack, in_decay, never, before_rel, r_over;
  logic [TIME_BITS-1:0] t, r;
  logic [TICK_W:0]      ad_sum;
  logic [TICK_W-1:0]    d;
  logic [TONE_W-1:0]    tone_c, tone_idx;
  logic [Q15_W-1:0]     level_new;
  logic [30:0]          rounded;
  logic [15:0]          mag;
  logic                 out_load;

  assign in_ready_o = (state_q == S_IDLE);

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q    <= RST_START_TIME;
      release_time_q  <= RST_RELEASE_TIME;
      tone_q          <= RST_TONE;
      attack_ticks_q  <= RST_ATTACK_TICKS;
      decay_ticks_q   <= RST_DECAY_TICKS;
      release_ticks_q <= RST_RELEASE_TICKS;
      levels_q        <= RST_LEVELS;
      stereo_gains_q  <= RST_STEREO_GAINS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_TIME:    start_time_q    <= cfg_wdata_i[TIME_BITS-1:0];
        REG_RELEASE_TIME:  release_time_q  <= cfg_wdata_i[TIME_BITS-1:0];
        REG_TONE:          tone_q          <= cfg_wdata_i[TONE_W-1:0];
        REG_ATTACK_TICKS:  attack_ticks_q  <= cfg_wdata_i[TICK_W-1:0];
        REG_DECAY_TICKS:   decay_ticks_q   <= cfg_wdata_i[TICK_W-1:0];
        REG_RELEASE_TICKS: release_ticks_q <= cfg_wdata_i[TICK_W-1:0];
        REG_LEVELS:        levels_q        <= cfg_wdata_i;
        REG_STEREO_GAINS:  stereo_gains_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // envelope phase decode
  assign peak       = sat15(levels_q[31:16]);
  assign sus        = sat15(levels_q[15:0]);
  assign started    = now_q >= start_time_q;
  assign t          = now_q - start_time_q;
  assign in_attack  = t < TIME_BITS'(attack_ticks_q);
  assign ad_sum     = {1'b0, attack_ticks_q} + {1'b0, decay_ticks_q};
  assign in_decay   = t < TIME_BITS'(ad_sum);
  assign d          = TICK_W'(t[TICK_W:0] - {1'b0, attack_ticks_q});
  assign never      = (release_time_q == '1);
  assign before_rel = now_q < release_time_q;
  assign r          = now_q - release_time_q;
  assign r_over     = r >= TIME_BITS'(release_ticks_q);

  // tone clamp and increment lookup
  always_comb begin
    if (tone_q < TONE_MIN) begin
      tone_c = TONE_MIN;
    end else if (tone_q > TONE_MAX) begin
      tone_c = TONE_MAX;
    end else begin
      tone_c = tone_q;
    end
    tone_idx = tone_c - TONE_MIN;
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_MULA: begin
        mul_a = 32'(x_q);
        mul_b = 32'(y_q);
      end
      S_MULP: begin
        mul_a = now_q;
        mul_b = inc_q;
      end
      S_MULG: begin
        mul_a = 32'(gain_q);
        mul_b = 32'(level_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = 64'(mul_a) * 64'(mul_b);

  // level divider
  assign div_start = (state_q == S_MULA);

  asv_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_res[NUM_W-1:0]),
    .den_i   (den_q),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // level from base and quotient
  always_comb begin
    unique case (lvl_mode_q)
      LVL_ADD: level_new = base_q + quot;
      LVL_SUB: level_new = base_q - quot;
      default: level_new = base_q;
    endcase
  end

  // rounding and sign of the output
  assign rounded  = 31'(prod_q) + ROUND_HALF;
  assign mag      = rounded[30:15];
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SETUP;
      S_SETUP: begin
        if (!started || (!in_attack && !in_decay)) begin
          if (!started || never || before_rel || r_over) begin
            state_d = S_LEVEL;
          end else begin
            state_d = S_MULA;
          end
        end else begin
          state_d = S_MULA;
        end
      end
      S_MULA:  state_d = S_DIV;
      S_DIV:   if (div_stat.done) state_d = S_LEVEL;
      S_LEVEL: state_d = S_MULP;
      S_MULP:  state_d = S_MULG;
      S_MULG:  state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      note_active_q <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LEVEL && started_q && !is_attack_q && level_new == '0) begin
        note_active_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      now_q  <= in_data_i.sample_time;
      chan_q <= in_data_i.channel;
    end
    if (state_q == S_SETUP) begin
      started_q   <= started;
      is_attack_q <= started && in_attack;
      inc_q       <= INC_LUT[tone_idx];
      gain_q      <= sat15(chan_q ? stereo_gains_q[31:16] : stereo_gains_q[15:0]);
      x_q         <= TICK_W'(t);
      y_q         <= peak;
      den_q       <= attack_ticks_q;
      base_q      <= '0;
      lvl_mode_q  <= LVL_DIRECT;
      priority if (!started) begin
        lvl_mode_q <= LVL_DIRECT;
      end else if (in_attack) begin
        lvl_mode_q <= LVL_ADD;
      end else if (in_decay) begin
        x_q    <= d;
        den_q  <= decay_ticks_q;
        base_q <= peak;
        if (peak >= sus) begin
          lvl_mode_q <= LVL_SUB;
          y_q        <= peak - sus;
        end else begin
          lvl_mode_q <= LVL_ADD;
          y_q        <= sus - peak;
        end
      end else if (never || before_rel) begin
        base_q <= sus;
      end else if (!r_over) begin
        lvl_mode_q <= LVL_SUB;
        x_q        <= TICK_W'(r);
        y_q        <= sus;
        den_q      <= release_ticks_q;
        base_q     <= sus;
      end
    end
    if (state_q == S_LEVEL) begin
      level_q <= level_new;
    end
    if (state_q == S_MULP) begin
      phase_pos_q <= (mul_res[31:0] != '0) && !mul_res[31];
    end
    if (state_q == S_MULG) begin
      prod_q <= mul_res[29:0];
    end
    if (out_load) begin
      out_q.sample_out   <= phase_pos_q ? $signed(mag) : -$signed(mag);
      out_q.still_active <= note_active_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `ASV_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == S_DIV)
  `ASV_ASSERT_NXT(a_active_sticky, !note_active_q, !note_active_q)
  `ASV_ASSERT_IMP(a_sample_bounded, out_valid_q, out_q.sample_out != 16'sh8000)
  `ASV_ASSERT_NXT(a_accept_to_setup, in_valid_i && in_ready_o, state_q == S_SETUP)

endmodule

`default_nettype wire

// ----- tb/voice_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// scoreboard for the adsr square voice core: envelope and square predictor, expected beats
// depends on asv_pkg for the beat types and register indexes
package voice_scoreboard_pkg;
  import asv_pkg::*;

  class voice_scoreboard;
    // shadow copy of the voice registers
    bit [31:0]   start_time;
    bit [31:0]   release_time;
    bit [6:0]    tone;
    bit [23:0]   attack_ticks;
    bit [23:0]   decay_ticks;
    bit [23:0]   release_ticks;
    bit [31:0]   levels;
    bit [31:0]   stereo_gains;
    bit          note_active;
    bit [31:0]   semitone_hz_q16 [12];
    asv_out_t    expected_samples [$];
    int unsigned mismatches;

    function new();
      start_time      = '0;
      release_time    = '1;
      tone            = 7'd49;
      attack_ticks    = 24'd480;
      decay_ticks     = 24'd4800;
      release_ticks   = 24'd4800;
      levels          = 32'h7FFF_8000;
      stereo_gains    = 32'h7FFF_7FFF;
      note_active     = 1'b1;
      mismatches      = 0;
      // 27.5 hz times 2^(k/12), q16.16
      semitone_hz_q16 = '{32'd1802240, 32'd1909407, 32'd2022946, 32'd2143237,
                          32'd2270680, 32'd2405702, 32'd2548752, 32'd2700309,
                          32'd2860878, 32'd3030994, 32'd3211227, 32'd3402176};
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_START_TIME:    start_time    = value;
        REG_RELEASE_TIME:  release_time  = value;
        REG_TONE:          tone          = value[6:0];
        REG_ATTACK_TICKS:  attack_ticks  = value[23:0];
        REG_DECAY_TICKS:   decay_ticks   = value[23:0];
        REG_RELEASE_TICKS: release_ticks = value[23:0];
        REG_LEVELS:        levels        = value;
        REG_STEREO_GAINS:  stereo_gains  = value;
        default: ;
      endcase
    endfunction

    function bit [63:0] clamp_q15(bit [15:0] v);
      return (v > 16'h7FFF) ? 64'h7FFF : 64'(v);
    endfunction

    // phase step per sample tick for the current tone
    function bit [31:0] tone_increment();
      bit [63:0] semi;
      bit [63:0] hz_q16;
      bit [63:0] step;
      semi = (tone < 7'd1) ? 64'd0 : (tone > 7'd96) ? 64'd95 : 64'(tone) - 64'd1;
      hz_q16 = 64'(semitone_hz_q16[semi % 12]) << (semi / 12);
      step = ((hz_q16 << 16) + 64'd24000) / 64'd48000;
      return step[31:0];
    endfunction

    // envelope level times gain times square sign, updates the active flag
    function asv_out_t next_sample(asv_in_t beat);
      bit [63:0] now, st, rel, peak, sus, gain, t, d, r, drop, level, mag, phase;
      bit        in_attack;
      asv_out_t  res;
      now       = 64'(beat.sample_time);
      st        = 64'(start_time);
      rel       = 64'(release_time);
      peak      = clamp_q15(levels[31:16]);
      sus       = clamp_q15(levels[15:0]);
      gain      = clamp_q15(beat.channel ? stereo_gains[31:16] : stereo_gains[15:0]);
      in_attack = 1'b0;
      level     = 0;
      res.sample_out = '0;
      if (now >= st) begin
        t = now - st;
        if (t < 64'(attack_ticks)) begin
          in_attack = 1'b1;
          level = (t * peak) / 64'(attack_ticks);
        end else if (t < 64'(attack_ticks) + 64'(decay_ticks)) begin
          d = t - 64'(attack_ticks);
          if (peak >= sus) level = peak - (d * (peak - sus)) / 64'(decay_ticks);
          else level = peak + (d * (sus - peak)) / 64'(decay_ticks);
        end else if (rel == 64'hFFFF_FFFF || now < rel) begin
          level = sus;
        end else begin
          // release ramp, held at zero once it runs out
          r = now - rel;
          if (release_ticks == '0) begin
            level = 0;
          end else begin
            drop = (r * sus) / 64'(release_ticks);
            level = (drop >= sus) ? 64'd0 : sus - drop;
          end
        end
        if (level == 0 && !in_attack) note_active = 1'b0;
        phase = (now * 64'(tone_increment())) & 64'hFFFF_FFFF;
        mag = (gain * level + 64'd16384) >> 15;
        if (phase != 0 && phase < 64'h8000_0000) res.sample_out = mag[15:0];
        else res.sample_out = 16'(64'd0 - mag);
      end
      res.still_active = note_active;
      return res;
    endfunction

    function void log_miss(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void note_beat(asv_in_t beat);
      expected_samples.push_back(next_sample(beat));
    endfunction

    function void check_beat(asv_out_t got);
      asv_out_t want;
      if (expected_samples.size() == 0) begin
        log_miss($sformatf("result beat with nothing pending: sample_out %0d still_active %0b",
                           got.sample_out, got.still_active));
        return;
      end
      want = expected_samples.pop_front();
      if (want.sample_out !== got.sample_out)
        log_miss($sformatf("sample_out: expected %0d, got %0d", want.sample_out,
                           got.sample_out));
      if (want.still_active !== got.still_active)
        log_miss($sformatf("still_active: expected %0b, got %0b", want.still_active,
                           got.still_active));
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// top testbench for adsr_square_voice_core: directed then random sample beats under stalls
// depends on asv_pkg, voice_scoreboard_pkg and the core rtl
module tb_top;
  import asv_pkg::*;
  import voice_scoreboard_pkg::*;

  localparam int unsigned IDLE_LIMIT        = 2000;
  localparam int unsigned SETTLE_CYCLES     = 30;
  localparam int unsigned RAND_SETTINGS     = 46;
  localparam int unsigned BEATS_PER_SETTING = 25;

  // one write image of all voice registers
  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] rel_time;
    logic [31:0] tone;
    logic [31:0] attack;
    logic [31:0] decay;
    logic [31:0] rel_ticks;
    logic [31:0] levels;
    logic [31:0] gains;
  } voice_setting_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = REG_START_TIME;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  asv_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  asv_out_t    out_data_o;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 47;
  int unsigned quiet_cycles  = 0;
  voice_scoreboard sb;

  adsr_square_voice_core uut (.*);

  always #5 clk_i = ~clk_i;

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // beat monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_beat(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_beat(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [31:0] tick, input logic chan);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample_time: tick, channel: chan};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  // registers change only once every pending beat is back and the core is quiet
  task automatic apply_setting(input voice_setting_t s);
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_START_TIME, s.start_time);
    write_reg(REG_RELEASE_TIME, s.rel_time);
    write_reg(REG_TONE, s.tone);
    write_reg(REG_ATTACK_TICKS, s.attack);
    write_reg(REG_DECAY_TICKS, s.decay);
    write_reg(REG_RELEASE_TICKS, s.rel_ticks);
    write_reg(REG_LEVELS, s.levels);
    write_reg(REG_STEREO_GAINS, s.gains);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [23:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3, 4:    return 16'($urandom);
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic voice_setting_t random_setting();
    voice_setting_t s;
    logic [23:0]    a;
    logic [23:0]    d;
    logic [31:0]    junk;
    // narrow registers sometimes carry junk in the unused upper bits
    junk = $urandom_range(0, 1) ? $urandom : '0;
    case ($urandom_range(0, 9))
      0:       s.start_time = '0;
      1:       s.start_time = '1;
      2, 3:    s.start_time = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      default: s.start_time = $urandom;
    endcase
    a = pick_ticks();
    d = pick_ticks();
    case ($urandom_range(0, 4))
      0:       s.rel_time = '1;
      1:       s.rel_time = $urandom;
      default: s.rel_time = s.start_time + a + d + $urandom_range(0, 400);
    endcase
    if ($urandom_range(0, 4) == 0) s.tone = {junk[31:7], 7'($urandom)};
    else s.tone = {junk[31:7], 7'($urandom_range(1, 96))};
    s.attack    = {junk[31:24], a};
    s.decay     = {junk[31:24], d};
    s.rel_ticks = {junk[31:24], pick_ticks()};
    s.levels    = {pick_q15(), pick_q15()};
    s.gains     = {pick_q15(), pick_q15()};
    return s;
  endfunction

  // sample tick aimed at one envelope phase or its edges, sometimes anywhere
  function automatic logic [31:0] pick_time();
    bit [63:0] st, a, d, r, rel, hold, base, span, off;
    st   = sb.start_time;
    a    = sb.attack_ticks;
    d    = sb.decay_ticks;
    r    = sb.release_ticks;
    rel  = sb.release_time;
    hold = st + a + d;
    base = 0;
    span = 0;
    case ($urandom_range(0, 6))
      0: begin
        base = st - 64'd700;
        span = 699;
      end
      1: begin
        base = st;
        span = a;
      end
      2: begin
        base = st + a;
        span = d;
      end
      3: begin
        base = hold;
        span = (rel > hold) ? rel - hold : 64'd50;
      end
      4: begin
        base = rel;
        span = r + r / 4 + 64'd3;
      end
      5: base = 64'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       base = st;
          1:       base = st + a;
          2:       base = hold;
          3:       base = rel;
          default: base = rel + r;
        endcase
        base = base - 64'd2;
        span = 4;
      end
    endcase
    off = {$urandom, $urandom} % (span + 1);
    return 32'(base + off);
  endfunction

  initial begin
    voice_setting_t s;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: first attack tick, attack, decay edge, sustain, last tick
    send_sample(32'd0, 1'b0);
    send_sample(32'd240, 1'b1);
    send_sample(32'd479, 1'b0);
    send_sample(32'd480, 1'b1);
    send_sample(32'd5280, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    end_burst();

    // no attack or decay, tone zero, saturated levels and left gain
    s = '{start_time: 32'd1000, rel_time: 32'd1052, tone: 32'h0000_0080, attack: '0,
          decay: '0, rel_ticks: 32'hAB00_0010, levels: '1, gains: 32'h0000_FFFF};
    apply_setting(s);
    send_sample(32'd999, 1'b0);
    send_sample(32'd1000, 1'b1);
    send_sample(32'd1051, 1'b0);
    send_sample(32'd1052, 1'b1);
    send_sample(32'd1060, 1'b0);
    send_sample(32'd1067, 1'b1);
    end_burst();

    // start near the top of time, rising decay, tone above range, never released
    s = '{start_time: 32'hFFFF_FF00, rel_time: '1, tone: 32'h0000_007F, attack: 32'd1,
          decay: 32'h00FF_FFFF, rel_ticks: 32'd1, levels: 32'h0100_7FFF,
          gains: 32'h7FFF_7FFF};
    apply_setting(s);
    send_sample(32'hFFFF_FF00, 1'b0);
    send_sample(32'hFFFF_FF01, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0010, 1'b1);
    end_burst();

    // longest attack, top tone
    s = '{start_time: '0, rel_time: 32'd100, tone: 32'd96, attack: 32'h00FF_FFFF,
          decay: 32'd1, rel_ticks: '0, levels: 32'h4000_2000, gains: 32'h1234_7FFF};
    apply_setting(s);
    send_sample(32'd50, 1'b0);
    send_sample(32'h00FF_FFFE, 1'b1);
    send_sample(32'h00FF_FFFF, 1'b0);
    end_burst();

    // zero sustain ends the note, then zero-length release
    s = '{start_time: '0, rel_time: 32'd10, tone: 32'd1, attack: 32'd2, decay: 32'd3,
          rel_ticks: '0, levels: 32'h7FFF_0000, gains: 32'hFFFF_8000};
    apply_setting(s);
    send_sample(32'd0, 1'b1);
    send_sample(32'd2, 1'b0);
    send_sample(32'd4, 1'b1);
    send_sample(32'd5, 1'b0);
    send_sample(32'd12, 1'b1);
    end_burst();

    // random settings, each with a burst of phase-aimed beats
    for (int p = 0; p < RAND_SETTINGS; p++) begin
      if (p < RAND_SETTINGS / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 47;
      end else if (p < 2 * RAND_SETTINGS / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(random_setting());
      repeat (BEATS_PER_SETTING) send_sample(pick_time(), 1'($urandom_range(0, 1)));
      end_burst();
    end

    // drain
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/asv_pkg.sv
sv/asv_divider.sv
sv/adsr_square_voice_core.sv
tb/voice_scoreboard_pkg.sv
tb/tb_top.sv
